// ----- sv/rdib_pkg.sv -----
// ----------------------------------------------------------------------------
// rdib_pkg
// Shared types, command codes and the zigzag scan table for the run-length
// dequantizing block decoder.
// ----------------------------------------------------------------------------
package rdib_pkg;

    // command codes of an input item
    localparam logic [1:0] CMD_DATA  = 2'd0;
    localparam logic [1:0] CMD_QUANT = 2'd1;
    localparam logic [1:0] CMD_SCALE = 2'd2;

    // padding halfword skipped while waiting for a dc word
    localparam logic [15:0] PAD_WORD = 16'hFE00;

    // clamp limits of a stored coefficient
    localparam logic signed [31:0] COEFF_MIN = -32'sd1024;
    localparam logic signed [31:0] COEFF_MAX = 32'sd1023;

    // tag that travels with one multiply-accumulate through the pipeline
    typedef struct packed {
        logic       pass;   // 0 first pass, 1 second pass
        logic [5:0] p;      // output index y*8+x
        logic [2:0] i;      // term of the dot product
    } mac_tag_t;

    // scan position to raster position
    function automatic logic [5:0] zigzag(input logic [5:0] k);
        logic [5:0] r;
        begin
            case (k)
                6'd0:  r = 6'd0;   6'd1:  r = 6'd1;   6'd2:  r = 6'd8;   6'd3:  r = 6'd16;
                6'd4:  r = 6'd9;   6'd5:  r = 6'd2;   6'd6:  r = 6'd3;   6'd7:  r = 6'd10;
                6'd8:  r = 6'd17;  6'd9:  r = 6'd24;  6'd10: r = 6'd32;  6'd11: r = 6'd25;
                6'd12: r = 6'd18;  6'd13: r = 6'd11;  6'd14: r = 6'd4;   6'd15: r = 6'd5;
                6'd16: r = 6'd12;  6'd17: r = 6'd19;  6'd18: r = 6'd26;  6'd19: r = 6'd33;
                6'd20: r = 6'd40;  6'd21: r = 6'd48;  6'd22: r = 6'd41;  6'd23: r = 6'd34;
                6'd24: r = 6'd27;  6'd25: r = 6'd20;  6'd26: r = 6'd13;  6'd27: r = 6'd6;
                6'd28: r = 6'd7;   6'd29: r = 6'd14;  6'd30: r = 6'd21;  6'd31: r = 6'd28;
                6'd32: r = 6'd35;  6'd33: r = 6'd42;  6'd34: r = 6'd49;  6'd35: r = 6'd56;
                6'd36: r = 6'd57;  6'd37: r = 6'd50;  6'd38: r = 6'd43;  6'd39: r = 6'd36;
                6'd40: r = 6'd29;  6'd41: r = 6'd22;  6'd42: r = 6'd15;  6'd43: r = 6'd23;
                6'd44: r = 6'd30;  6'd45: r = 6'd37;  6'd46: r = 6'd44;  6'd47: r = 6'd51;
                6'd48: r = 6'd58;  6'd49: r = 6'd59;  6'd50: r = 6'd52;  6'd51: r = 6'd45;
                6'd52: r = 6'd38;  6'd53: r = 6'd31;  6'd54: r = 6'd39;  6'd55: r = 6'd46;
                6'd56: r = 6'd53;  6'd57: r = 6'd60;  6'd58: r = 6'd61;  6'd59: r = 6'd54;
                6'd60: r = 6'd47;  6'd61: r = 6'd55;  6'd62: r = 6'd62;  default: r = 6'd63;
            endcase
            return r;
        end
    endfunction

endpackage

// ----- sv/rdib_item_if.sv -----
// ----------------------------------------------------------------------------
// rdib_item_if
// Input channel: command, halfword, table select and entry index.
// ----------------------------------------------------------------------------
interface rdib_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [15:0] word;
    logic        table_select;
    logic [5:0]  entry_index;

    modport source (output valid, cmd, word, table_select, entry_index, input ready);
    modport sink   (input valid, cmd, word, table_select, entry_index, output ready);
endinterface

// ----- sv/rdib_result_if.sv -----
// ----------------------------------------------------------------------------
// rdib_result_if
// Output channel: one idct sample with its position and end-of-block flag.
// ----------------------------------------------------------------------------
interface rdib_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic [5:0]         position;
    logic               last;

    modport source (output valid, sample, position, last, input ready);
    modport sink   (input valid, sample, position, last, output ready);
endinterface

// ----- sv/rle_dequant_idct_block_decoder_core.sv -----
// ----------------------------------------------------------------------------
// rle_dequant_idct_block_decoder_core
// Run-length decode and dequantize one 8x8 block, then run a two-pass
// matrix idct on one shared multiplier and stream out 64 samples.
// ----------------------------------------------------------------------------
// A load command or padding word is handled on acceptance; a coefficient word
//   goes through a registered table read, up to two multiplies and a store.
// The end word starts the idct: 1024 multiply-accumulates on the single
//   multiplier, one per cycle, through read, product and accumulate registers,
//   then 64 samples at one per cycle when the sink is ready.
// Reset (rst_n low, asynchronous) returns to waiting for a dc word; tables
//   and matrix hold nothing defined until loaded.
module rle_dequant_idct_block_decoder_core (
    input  logic clk,
    input  logic rst_n,
    rdib_item_if.sink     item,
    rdib_result_if.source result
);
    import rdib_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DQ1   = 3'd1;
    localparam logic [2:0] S_DQ2   = 3'd2;
    localparam logic [2:0] S_STORE = 3'd3;
    localparam logic [2:0] S_IDCT  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]  state_reg;
    logic        in_block_reg;
    logic        chroma_reg;
    logic [5:0]  qscale_reg;
    logic [5:0]  scan_reg;
    logic [5:0]  k_reg;
    logic signed [9:0] v_reg;
    logic [63:0] coeff_valid_reg;

    logic [7:0]         quant_mem_reg [128];
    logic signed [15:0] scale_mem_reg [64];
    logic signed [10:0] coeff_mem_reg [64];
    logic signed [47:0] part_mem_reg  [64];
    logic signed [15:0] samp_mem_reg  [64];

    logic [7:0]         quant_rd_reg;
    logic signed [15:0] scale_rd_reg;
    logic signed [10:0] coeff_rd_reg;
    logic signed [47:0] part_rd_reg;

    logic [9:0]  step_reg;
    logic        issue_reg;
    logic        s1_vld_reg;
    logic        s2_vld_reg;
    mac_tag_t    s1_tag_reg;
    mac_tag_t    s2_tag_reg;
    logic signed [47:0] acc_reg;

    logic [6:0]  out_cnt_reg;
    logic        out_valid_reg;
    logic signed [15:0] out_sample_reg;
    logic [5:0]  out_pos_reg;
    logic        out_last_reg;

    logic accept;
    logic [6:0] next_pos;
    logic [6:0] q_addr;
    logic signed [9:0] in_v;

    // input transfer and next scan position
    assign item.ready = (state_reg == S_IDLE);
    assign accept     = item.valid && item.ready;
    assign in_v       = item.word[9:0];
    assign next_pos   = {1'b0, scan_reg} + {1'b0, item.word[15:10]} + 7'd1;
    assign q_addr     = in_block_reg ? {chroma_reg, next_pos[5:0]}
                                     : {item.table_select, 6'd0};

    // idct read addresses from the step counter
    logic       st_pass;
    logic [2:0] st_i;
    logic [2:0] st_x;
    logic [2:0] st_y;
    logic [5:0] scale_addr;
    assign st_pass    = step_reg[9];
    assign st_y       = step_reg[8:6];
    assign st_x       = step_reg[5:3];
    assign st_i       = step_reg[2:0];
    assign scale_addr = st_pass ? {st_i, st_x} : {st_i, st_y};

    // shared multiplier operand selection
    logic signed [30:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [47:0] prod;
    logic               mul_en;
    always_comb
    begin
        unique case (state_reg)
            S_DQ1:
            begin
                mul_a = {{21{v_reg[9]}}, v_reg};
                mul_b = {9'd0, quant_rd_reg};
            end
            S_DQ2:
            begin
                mul_a = prod[30:0];
                mul_b = {11'd0, qscale_reg};
            end
            default:
            begin
                mul_a = s1_tag_reg.pass ? part_rd_reg[30:0]
                                        : {{20{coeff_rd_reg[10]}}, coeff_rd_reg};
                mul_b = {scale_rd_reg[15], scale_rd_reg};
            end
        endcase
    end
    assign mul_en = (state_reg == S_DQ1) || (state_reg == S_DQ2) || s1_vld_reg;

    rdib_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // dequantized value (ac: product plus 4, divided by 8 toward zero) and clamp
    logic signed [31:0] dq_t;
    logic signed [31:0] dq_div;
    logic signed [31:0] dq_val;
    logic signed [10:0] dq_clamped;
    logic [5:0]         store_addr;
    always_comb
    begin
        dq_t   = prod[31:0] + 32'sd4;
        dq_div = dq_t[31] ? ((dq_t + 32'sd7) >>> 3) : (dq_t >>> 3);
        if (qscale_reg == 6'd0)
            dq_val = {{21{v_reg[9]}}, v_reg, 1'b0};
        else if (k_reg == 6'd0)
            dq_val = prod[31:0];
        else
            dq_val = dq_div;
        if (dq_val < COEFF_MIN)
            dq_clamped = COEFF_MIN[10:0];
        else if (dq_val > COEFF_MAX)
            dq_clamped = COEFF_MAX[10:0];
        else
            dq_clamped = dq_val[10:0];
        store_addr = (qscale_reg == 6'd0) ? k_reg : zigzag(k_reg);
    end

    // accumulator of the current dot product
    logic signed [47:0] acc_sum;
    logic signed [15:0] samp_val;
    assign acc_sum  = ((s2_tag_reg.i == 3'd0) ? 48'sd0 : acc_reg) + prod;
    assign samp_val = acc_sum[47:32] + {15'd0, acc_sum[31]};

    // memories: loads, coefficient store, idct scratch and sample buffer
    always_ff @(posedge clk)
    begin
        if (accept && item.cmd == CMD_QUANT)
            quant_mem_reg[{item.table_select, item.entry_index}] <= item.word[7:0];
        if (accept && item.cmd == CMD_DATA)
            quant_rd_reg <= quant_mem_reg[q_addr];
        if (accept && item.cmd == CMD_SCALE)
            scale_mem_reg[item.entry_index] <= item.word;
        scale_rd_reg <= scale_mem_reg[scale_addr];
        if (state_reg == S_STORE)
            coeff_mem_reg[store_addr] <= dq_clamped;
        coeff_rd_reg <= coeff_valid_reg[{st_i, st_x}] ? coeff_mem_reg[{st_i, st_x}] : 11'sd0;
        part_rd_reg  <= part_mem_reg[{st_y, st_i}];
        if (s2_vld_reg && s2_tag_reg.i == 3'd7 && !s2_tag_reg.pass)
            part_mem_reg[s2_tag_reg.p] <= acc_sum;
        if (s2_vld_reg && s2_tag_reg.i == 3'd7 && s2_tag_reg.pass)
            samp_mem_reg[s2_tag_reg.p] <= samp_val;
        if (s2_vld_reg)
            acc_reg <= acc_sum;
        if (state_reg == S_OUT && !out_cnt_reg[6] && (!out_valid_reg || result.ready))
        begin
            out_sample_reg <= samp_mem_reg[out_cnt_reg[5:0]];
            out_pos_reg    <= out_cnt_reg[5:0];
            out_last_reg   <= (out_cnt_reg == 7'd63);
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            in_block_reg    <= 1'b0;
            chroma_reg      <= 1'b0;
            qscale_reg      <= 6'd0;
            scan_reg        <= 6'd0;
            k_reg           <= 6'd0;
            v_reg           <= 10'sd0;
            coeff_valid_reg <= 64'd0;
            step_reg        <= 10'd0;
            issue_reg       <= 1'b0;
            s1_vld_reg      <= 1'b0;
            s2_vld_reg      <= 1'b0;
            s1_tag_reg      <= '0;
            s2_tag_reg      <= '0;
            out_cnt_reg     <= 7'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            // mac pipeline tags
            s1_vld_reg <= issue_reg;
            s1_tag_reg <= '{pass: st_pass, p: {st_y, st_x}, i: st_i};
            s2_vld_reg <= s1_vld_reg;
            s2_tag_reg <= s1_tag_reg;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && item.cmd == CMD_DATA)
                    begin
                        if (!in_block_reg)
                        begin
                            if (item.word != PAD_WORD)
                            begin
                                coeff_valid_reg <= 64'd0;
                                in_block_reg    <= 1'b1;
                                chroma_reg      <= item.table_select;
                                qscale_reg      <= item.word[15:10];
                                scan_reg        <= 6'd0;
                                k_reg           <= 6'd0;
                                v_reg           <= in_v;
                                state_reg <= (item.word[15:10] == 6'd0) ? S_STORE : S_DQ1;
                            end
                        end
                        else if (next_pos[6])
                        begin
                            in_block_reg <= 1'b0;
                            scan_reg     <= 6'd0;
                            step_reg     <= 10'd0;
                            issue_reg    <= 1'b1;
                            state_reg    <= S_IDCT;
                        end
                        else
                        begin
                            scan_reg  <= next_pos[5:0];
                            k_reg     <= next_pos[5:0];
                            v_reg     <= in_v;
                            state_reg <= (qscale_reg == 6'd0) ? S_STORE : S_DQ1;
                        end
                    end
                end
                S_DQ1:
                begin
                    state_reg <= (k_reg == 6'd0) ? S_STORE : S_DQ2;
                end
                S_DQ2:
                begin
                    state_reg <= S_STORE;
                end
                S_STORE:
                begin
                    coeff_valid_reg[store_addr] <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_IDCT:
                begin
                    if (issue_reg)
                    begin
                        step_reg <= step_reg + 10'd1;
                        if (step_reg == 10'd1023)
                            issue_reg <= 1'b0;
                    end
                    if (s2_vld_reg && s2_tag_reg.pass && s2_tag_reg.p == 6'd63
                        && s2_tag_reg.i == 3'd7)
                    begin
                        out_cnt_reg <= 7'd0;
                        state_reg   <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_cnt_reg[6] && (!out_valid_reg || result.ready))
                    begin
                        out_valid_reg <= 1'b1;
                        out_cnt_reg   <= out_cnt_reg + 7'd1;
                    end
                    else if (out_valid_reg && result.ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                    else if (!out_valid_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // output register
    assign result.valid    = out_valid_reg;
    assign result.sample   = out_sample_reg;
    assign result.position = out_pos_reg;
    assign result.last     = out_last_reg;
endmodule

// ----- sv/rdib_mul.sv -----
// ----------------------------------------------------------------------------
// rdib_mul
// Shared signed multiplier with a registered product, used for
// dequantization and for every idct multiply-accumulate.
// ----------------------------------------------------------------------------
module rdib_mul (
    input  logic               clk,
    input  logic               en,
    input  logic signed [30:0] a,
    input  logic signed [16:0] b,
    output logic signed [47:0] prod
);
    logic signed [47:0] prod_reg;

    // product register, loaded when a step uses the unit
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;
endmodule

// ----- sv/rdib_chk.sv -----
// ----------------------------------------------------------------------------
// rdib_chk
// Port-level checks of the block decoder, bound to the top level.
// ----------------------------------------------------------------------------
module rdib_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] out_sample,
    input logic [5:0]  out_position,
    input logic        out_last
);
    // no input is taken while samples are streaming
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while output valid");

    // last flag only on the final position
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_last) |-> (out_position == 6'd63))
        else $error("last flag on wrong position");

    // positions advance by one between transfers
    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !out_last) ##1 out_valid
        |-> (out_position == $past(out_position) + 6'd1))
        else $error("position did not advance by one");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_sample)))
        else $error("stalled result changed");
endmodule

bind rle_dequant_idct_block_decoder_core rdib_chk u_rdib_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (item.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .out_sample   (result.sample),
    .out_position (result.position),
    .out_last     (result.last)
);

// ----- bench/rle_dequant_idct_block_decoder_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rle_dequant_idct_block_decoder_core_tb
// Drives quant table and scale matrix loads plus run-length coded blocks into
// the decoder, predicts every idct sample with a local block decoder and
// compares each sample transfer with the oldest predicted sample.
// ----------------------------------------------------------------------------
module rle_dequant_idct_block_decoder_core_tb;
    import rdib_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic signed [15:0] sample;
        logic [5:0]         position;
        logic               last;
    } pixel_t;

    // scan position to raster position of the 8x8 block
    localparam logic [5:0] SCAN_ORDER [64] = '{
         0,  1,  8, 16,  9,  2,  3, 10, 17, 24, 32, 25, 18, 11,  4,  5,
        12, 19, 26, 33, 40, 48, 41, 34, 27, 20, 13,  6,  7, 14, 21, 28,
        35, 42, 49, 56, 57, 50, 43, 36, 29, 22, 15, 23, 30, 37, 44, 51,
        58, 59, 52, 45, 38, 31, 39, 46, 53, 60, 61, 54, 47, 55, 62, 63
    };

    logic clk;
    logic rst_n;

    rdib_item_if   itm ();
    rdib_result_if res ();

    rle_dequant_idct_block_decoder_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (itm),
        .result (res)
    );

    // decoder state mirrored by the testbench
    logic [7:0]          quant_mem [128];
    logic signed [15:0]  scale_mem [64];
    int                  coeff_mem [64];
    int unsigned         scan_at;
    int unsigned         qscale;
    bit                  block_open;
    bit                  chroma_sel;

    pixel_t pixel_q [$];
    int     mismatches;
    int     samples_seen;
    int     blocks_done;
    int     items_sent;
    bit     sender_burst;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // global watchdog
    initial
    begin
        #20ms;
        $display("rle_dequant_idct_block_decoder_core test failed");
        $finish;
    end

    function automatic int sext10(input logic [15:0] w);
        return int'(signed'(w[9:0]));
    endfunction

    function automatic void store_coeff(input int unsigned k, input int v);
        int c;
        logic [5:0] p;
        c = (v < -1024) ? -1024 : ((v > 1023) ? 1023 : v);
        p = (qscale == 0) ? k[5:0] : SCAN_ORDER[k[5:0]];
        coeff_mem[p] = c;
    endfunction

    // two-pass matrix idct, predicted samples go to the queue
    function automatic void predict_idct();
        longint partial [64];
        longint acc;
        pixel_t px;
        for (int x = 0; x < 8; x++)
            for (int y = 0; y < 8; y++)
            begin
                acc = 0;
                for (int i = 0; i < 8; i++)
                    acc += longint'(scale_mem[i*8+y]) * longint'(coeff_mem[i*8+x]);
                partial[y*8+x] = acc;
            end
        for (int y = 0; y < 8; y++)
            for (int x = 0; x < 8; x++)
            begin
                acc = 0;
                for (int i = 0; i < 8; i++)
                    acc += partial[y*8+i] * longint'(scale_mem[i*8+x]);
                acc = (acc >>> 32) + longint'(acc[31]);
                px.sample   = acc[15:0];
                px.position = 6'(y*8+x);
                px.last     = (y == 7 && x == 7);
                pixel_q.insert(pixel_q.size(), px);
            end
    endfunction

    // one accepted input item applied to the mirrored state
    function automatic void decode_item(input logic [1:0] cmd, input logic [15:0] w,
                                        input logic sel, input logic [5:0] idx);
        int v;
        if (cmd == CMD_QUANT)
            quant_mem[{sel, idx}] = w[7:0];
        else if (cmd == CMD_SCALE)
            scale_mem[idx] = w;
        else if (cmd == CMD_DATA)
        begin
            if (!block_open)
            begin
                if (w != PAD_WORD)
                begin
                    for (int i = 0; i < 64; i++)
                        coeff_mem[i] = 0;
                    block_open = 1'b1;
                    chroma_sel = sel;
                    qscale     = w[15:10];
                    scan_at    = 0;
                    v = sext10(w);
                    v = (qscale == 0) ? v * 2 : v * int'(quant_mem[{chroma_sel, 6'd0}]);
                    store_coeff(0, v);
                end
            end
            else
            begin
                scan_at = (scan_at + w[15:10] + 1) & 127;
                if (scan_at >= 64)
                begin
                    block_open = 1'b0;
                    scan_at    = 0;
                    blocks_done++;
                    predict_idct();
                end
                else
                begin
                    v = sext10(w);
                    if (qscale == 0)
                        v = v * 2;
                    else
                        v = (v * int'(quant_mem[{chroma_sel, scan_at[5:0]}])
                             * int'(qscale) + 4) / 8;
                    store_coeff(scan_at, v);
                end
            end
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (sender_burst || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // one transfer on the input channel; returns at the accepting edge
    task automatic send_item(input logic [1:0] cmd, input logic [15:0] w,
                             input logic sel, input logic [5:0] idx);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            itm.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        itm.valid        <= 1'b1;
        itm.cmd          <= cmd;
        itm.word         <= w;
        itm.table_select <= sel;
        itm.entry_index  <= idx;
        @(posedge clk);
        while (!itm.ready)
            @(posedge clk);
        decode_item(cmd, w, sel, idx);
        items_sent++;
    endtask

    task automatic send_ac(input int run, input int ac);
        logic [15:0] w;
        w = {6'(run), 10'(ac)};
        send_item(CMD_DATA, w, 1'($urandom), 6'($urandom));
    endtask

    task automatic drain_samples();
        itm.valid <= 1'b0;
        while (pixel_q.size() != 0)
            @(posedge clk);
    endtask

    // every quant entry and every scale entry gets a value
    task automatic test_load_tables();
        for (int t = 0; t < 2; t++)
            for (int i = 0; i < 64; i++)
                send_item(CMD_QUANT, 16'($urandom), 1'(t), 6'(i));
        for (int i = 0; i < 64; i++)
            send_item(CMD_SCALE, (i == 0) ? 16'h7FFF : ((i == 9) ? 16'h8000 : 16'($urandom)),
                      1'($urandom), 6'(i));
    endtask

    task automatic test_directed_blocks();
        // padding, then scale 0 block with extreme dc and ac, zero-run ac
        send_item(CMD_DATA, PAD_WORD, 1'b0, 6'd0);
        send_item(CMD_UNUSED, 16'hFFFF, 1'b1, 6'd63);
        send_item(CMD_DATA, 16'h01FF, 1'b0, 6'd0);
        send_ac(0, -512);
        send_ac(0, 511);
        send_ac(61, 1);
        send_item(CMD_DATA, PAD_WORD, 1'b0, 6'd0);
        // max scale, full quant entry, clamping; load during block
        send_item(CMD_QUANT, 16'h00FF, 1'b1, 6'd1);
        send_item(CMD_QUANT, 16'h00FF, 1'b1, 6'd0);
        send_item(CMD_DATA, 16'hFE00 | 16'h0200 | 16'h0001, 1'b1, 6'd0);
        send_item(CMD_QUANT, 16'h0001, 1'b1, 6'd5);
        send_ac(0, 511);
        send_ac(1, -512);
        send_ac(63, 7);
        // run landing exactly on the last position, then end
        send_item(CMD_DATA, 16'h0400 | 16'h0155, 1'b0, 6'd0);
        send_ac(62, -1);
        send_item(CMD_UNUSED, 16'h0000, 1'b0, 6'd0);
        send_ac(0, 0);
        drain_samples();
    endtask

    // a block with random contents; mostly well formed, some noise
    task automatic random_block();
        int n;
        int pos;
        int run;
        int r;
        logic [15:0] dc;
        if ($urandom_range(0, 3) == 0)
            send_item(CMD_DATA, PAD_WORD, 1'($urandom), 6'($urandom));
        do
            dc = 16'($urandom);
        while (dc == PAD_WORD);
        if ($urandom_range(0, 4) == 0)
            dc[15:10] = 6'd0;
        send_item(CMD_DATA, dc, 1'($urandom), 6'($urandom));
        n = $urandom_range(0, 8);
        pos = 0;
        for (int j = 0; j < n; j++)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                send_item(CMD_UNUSED, 16'($urandom), 1'($urandom), 6'($urandom));
            else if (r < 14)
                send_item(2'($urandom_range(1, 2)), 16'($urandom), 1'($urandom), 6'($urandom));
            else if (pos < 62)
            begin
                run = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 62 - pos - 1)
                                                  : $urandom_range(0, 3);
                if (pos + run + 1 > 63)
                    run = 62 - pos;
                pos += run + 1;
                send_ac(run, $urandom);
            end
        end
        // end of block: padding code or an overrunning run
        if ($urandom_range(0, 1) == 0)
            send_item(CMD_DATA, PAD_WORD, 1'($urandom), 6'($urandom));
        else
            send_ac($urandom_range(63 - pos, 63), $urandom);
    endtask

    task automatic test_random_blocks();
        while (items_sent < 430 || blocks_done < 40)
        begin
            sender_burst = ($urandom_range(0, 5) == 0);
            random_block();
        end
        sender_burst = 1'b0;
    endtask

    // hold the sender until the decoder has emitted all pending samples
    task automatic test_pause_until_drained();
        random_block();
        drain_samples();
        random_block();
    endtask

    // sample checker
    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && res.valid && res.ready)
        begin
            samples_seen++;
            if (pixel_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected sample %0d at position %0d", res.sample, res.position);
            end
            else
            begin
                want = pixel_q.pop_front();
                if (res.sample !== want.sample || res.position !== want.position ||
                    res.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"sample mismatch: expected %0d pos %0d last %0b,",
                                  " got %0d pos %0d last %0b"},
                                 want.sample, want.position, want.last,
                                 res.sample, res.position, res.last);
                end
            end
        end
    end

    // sink ready: runs of always ready, random ready, and long stalls
    int stall_mode;
    int stall_left;
    int mode_left;
    always @(posedge clk)
    begin
        int r;
        r = $urandom_range(0, 99);
        if (mode_left == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            mode_left  <= $urandom_range(50, 400);
        end
        else
            mode_left <= mode_left - 1;
        if (stall_left > 0)
        begin
            res.ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (stall_mode == 0)
            res.ready <= 1'b1;
        else if (stall_mode == 1)
            res.ready <= (r < 70);
        else if (r < 3)
        begin
            res.ready  <= 1'b0;
            stall_left <= $urandom_range(10, 60);
        end
        else
            res.ready <= 1'b1;
    end

    initial
    begin
        rst_n            = 1'b0;
        itm.valid        = 1'b0;
        itm.cmd          = CMD_DATA;
        itm.word         = 16'h0000;
        itm.table_select = 1'b0;
        itm.entry_index  = 6'd0;
        res.ready        = 1'b0;
        stall_mode = 0;
        stall_left = 0;
        mode_left  = 0;
        mismatches = 0;
        samples_seen = 0;
        blocks_done  = 0;
        items_sent   = 0;
        sender_burst = 1'b0;
        block_open = 1'b0;
        scan_at = 0;
        qscale = 0;
        chroma_sel = 1'b0;
        for (int i = 0; i < 64; i++)
            coeff_mem[i] = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_load_tables();
        test_directed_blocks();
        test_pause_until_drained();
        test_random_blocks();
        drain_samples();
        repeat (50) @(posedge clk);

        $display("covered %0d input transfers, %0d blocks, %0d samples checked",
                 items_sent, blocks_done, samples_seen);
        if (mismatches == 0 && pixel_q.size() == 0)
            $display("rle_dequant_idct_block_decoder_core test passed");
        else
            $display("rle_dequant_idct_block_decoder_core test failed");
        $finish;
    end

endmodule
